// ===== sv/ffd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants for the fixed frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

   localparam int FRAME_LEN   = 19;
   localparam int POS_W       = $clog2(FRAME_LEN);
   localparam int QUEUE_DEPTH = 2;

   typedef logic [POS_W-1:0] pos_type;

   localparam logic [7:0] HEAD_A   = 8'hAA;
   localparam logic [7:0] HEAD_B   = 8'h55;
   localparam logic [7:0] LEN_BYTE = 8'h0E;
   localparam logic [7:0] TAIL_A   = 8'h0D;
   localparam logic [7:0] TAIL_B   = 8'h0A;
   localparam logic [7:0] FLAG_MAX = 8'd1;
   localparam logic [15:0] CONF_MAX_STORABLE = 16'd1023;

   localparam logic [7:0]  SRC_RESET   = 8'd5;
   localparam logic [7:0]  DST_RESET   = 8'd4;
   localparam logic [7:0]  MSGID_RESET = 8'd66;
   localparam logic [15:0] CONF_LIMIT_RESET = 16'd1000;

   // byte offsets within the frame
   localparam pos_type OFS_HEAD_A = pos_type'(0);
   localparam pos_type OFS_HEAD_B = pos_type'(1);
   localparam pos_type OFS_LEN    = pos_type'(2);
   localparam pos_type OFS_SRC    = pos_type'(3);
   localparam pos_type OFS_DST    = pos_type'(4);
   localparam pos_type OFS_MSGID  = pos_type'(5);
   localparam pos_type OFS_VALID  = pos_type'(6);
   localparam pos_type OFS_LOST   = pos_type'(7);
   localparam pos_type OFS_CONF_L = pos_type'(8);
   localparam pos_type OFS_CONF_H = pos_type'(9);
   localparam pos_type OFS_LAT_L  = pos_type'(10);
   localparam pos_type OFS_LAT_H  = pos_type'(11);
   localparam pos_type OFS_HDG_L  = pos_type'(12);
   localparam pos_type OFS_HDG_H  = pos_type'(13);
   localparam pos_type OFS_CURV_L = pos_type'(14);
   localparam pos_type OFS_CURV_H = pos_type'(15);
   localparam pos_type OFS_MARKER = pos_type'(16);
   localparam pos_type OFS_TAIL_A = pos_type'(17);
   localparam pos_type OFS_TAIL_B = pos_type'(18);

   typedef enum logic [1:0] {
      CSR_SRC_ADDR   = 2'd0,
      CSR_DST_ADDR   = 2'd1,
      CSR_MSG_ID     = 2'd2,
      CSR_CONF_LIMIT = 2'd3
   } csr_idx_type;

   typedef enum logic {
      MODE_DATA   = 1'b0,
      MODE_RESYNC = 1'b1
   } mode_type;

   // one classified frame, passed from front to back
   typedef struct packed {
      logic               ok;
      logic               line_valid;
      logic [7:0]         lines_lost;
      logic [9:0]         confidence;
      logic signed [15:0] lateral;
      logic signed [15:0] heading;
      logic signed [15:0] curvature;
      logic               marker;
      logic [31:0]        time_ms;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

// ===== sv/ffd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_req_if
// Request channel: received serial bytes or resync.
// ----------------------------------------------------------------------------
interface ffd_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  byte_value;
   logic [31:0] now_ms;

   modport source (output valid, mode, byte_value, now_ms, input ready);
   modport sink   (input valid, mode, byte_value, now_ms, output ready);
endinterface
`default_nettype wire

// ===== sv/ffd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_rsp_if
// Response channel: frame verdict and latest line record.
// ----------------------------------------------------------------------------
interface ffd_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_ok;
   logic               line_valid;
   logic [7:0]         lines_lost;
   logic [9:0]         confidence;
   logic signed [15:0] lateral_offset;
   logic signed [15:0] heading_offset;
   logic signed [15:0] curvature;
   logic               marker_seen;
   logic [31:0]        received_ms;
   logic [31:0]        good_frames;
   logic [31:0]        bad_frames;

   modport source (output valid, frame_ok, line_valid, lines_lost, confidence,
                   lateral_offset, heading_offset, curvature, marker_seen,
                   received_ms, good_frames, bad_frames, input ready);
   modport sink   (input valid, frame_ok, line_valid, lines_lost, confidence,
                   lateral_offset, heading_offset, curvature, marker_seen,
                   received_ms, good_frames, bad_frames, output ready);
endinterface
`default_nettype wire

// ===== sv/ffd_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ffd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ffd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_queue
// Short queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module ffd_queue #(
   parameter int DEPTH = ffd_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  ffd_pkg::entry_type        push_data,
   input  wire logic                 pop,
   output ffd_pkg::entry_type        pop_data,
   output ffd_pkg::q_status_type     status
);
   import ffd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== sv/ffd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_front
// Header hunt, byte collection and frame check; holds the csr registers.
// ----------------------------------------------------------------------------
module ffd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   ffd_req_if.sink                req_ch,
   ffd_csr_if.sink                csr_ch,
   input  ffd_pkg::q_status_type  q_status,
   output logic                   push,
   output ffd_pkg::entry_type     push_data
);
   import ffd_pkg::*;

   logic        accept;
   logic        csr_write;
   logic [7:0]  b;

   pos_type     pos_ff, pos_in;
   logic        fixed_ok_ff, fixed_ok_in;

   logic [7:0]  src_cfg_ff, dst_cfg_ff, msgid_cfg_ff;
   logic [15:0] conf_limit_ff;

   // captured frame bytes
   logic [7:0]  src_ff, dst_ff, msgid_ff, lost_ff;
   logic        valid_bit_ff, marker_ff;
   logic [15:0] conf_ff, lat_ff, hdg_ff, curv_ff;

   logic        frame_ok;

   assign req_ch.ready = !q_status.full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign b            = req_ch.byte_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cfg_ff    <= SRC_RESET;
         dst_cfg_ff    <= DST_RESET;
         msgid_cfg_ff  <= MSGID_RESET;
         conf_limit_ff <= CONF_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_SRC_ADDR:   src_cfg_ff    <= csr_ch.data[7:0];
            CSR_DST_ADDR:   dst_cfg_ff    <= csr_ch.data[7:0];
            CSR_MSG_ID:     msgid_cfg_ff  <= csr_ch.data[7:0];
            CSR_CONF_LIMIT: conf_limit_ff <= csr_ch.data;
            default:        ;
         endcase
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      fixed_ok_in = fixed_ok_ff;
      push        = 1'b0;
      if (accept) begin
         if (mode_type'(req_ch.mode) == MODE_RESYNC) begin
            pos_in = OFS_HEAD_A;
         end else if (pos_ff == OFS_HEAD_A) begin
            if (b == HEAD_A) begin
               pos_in = OFS_HEAD_B;
            end
         end else if (pos_ff == OFS_HEAD_B) begin
            // a repeated header byte keeps the frame start
            if (b == HEAD_B) begin
               pos_in = OFS_LEN;
            end else if (b != HEAD_A) begin
               pos_in = OFS_HEAD_A;
            end
         end else if (pos_ff == OFS_TAIL_B) begin
            push   = 1'b1;
            pos_in = OFS_HEAD_A;
         end else begin
            pos_in = pos_ff + pos_type'(1);
            case (pos_ff)
               OFS_LEN:    fixed_ok_in = (b == LEN_BYTE);
               OFS_VALID:  fixed_ok_in = fixed_ok_ff && (b <= FLAG_MAX);
               OFS_MARKER: fixed_ok_in = fixed_ok_ff && (b <= FLAG_MAX);
               OFS_TAIL_A: fixed_ok_in = fixed_ok_ff && (b == TAIL_A);
               default:    ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= OFS_HEAD_A;
         fixed_ok_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         fixed_ok_ff <= fixed_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mode_type'(req_ch.mode) == MODE_DATA) begin
         case (pos_ff)
            OFS_SRC:    src_ff        <= b;
            OFS_DST:    dst_ff        <= b;
            OFS_MSGID:  msgid_ff      <= b;
            OFS_VALID:  valid_bit_ff  <= b[0];
            OFS_LOST:   lost_ff       <= b;
            OFS_CONF_L: conf_ff[7:0]  <= b;
            OFS_CONF_H: conf_ff[15:8] <= b;
            OFS_LAT_L:  lat_ff[7:0]   <= b;
            OFS_LAT_H:  lat_ff[15:8]  <= b;
            OFS_HDG_L:  hdg_ff[7:0]   <= b;
            OFS_HDG_H:  hdg_ff[15:8]  <= b;
            OFS_CURV_L: curv_ff[7:0]  <= b;
            OFS_CURV_H: curv_ff[15:8] <= b;
            OFS_MARKER: marker_ff     <= b[0];
            default:    ;
         endcase
      end
   end

   // address and limit checks use the registers as they stand at the last byte
   assign frame_ok = fixed_ok_ff && (b == TAIL_B)
                     && (src_ff == src_cfg_ff) && (dst_ff == dst_cfg_ff)
                     && (msgid_ff == msgid_cfg_ff)
                     && (conf_ff <= conf_limit_ff) && (conf_ff <= CONF_MAX_STORABLE);

   always_comb begin
      push_data.ok         = frame_ok;
      push_data.line_valid = valid_bit_ff;
      push_data.lines_lost = lost_ff;
      push_data.confidence = conf_ff[9:0];
      push_data.lateral    = lat_ff;
      push_data.heading    = hdg_ff;
      push_data.curvature  = curv_ff;
      push_data.marker     = marker_ff;
      push_data.time_ms    = req_ch.now_ms;
   end

endmodule
`default_nettype wire

// ===== sv/ffd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_back
// Applies classified frames to the line record and counters, drives responses.
// ----------------------------------------------------------------------------
module ffd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  ffd_pkg::q_status_type  q_status,
   input  ffd_pkg::entry_type     pop_data,
   output logic                   pop,
   ffd_rsp_if.source              rsp_ch
);
   import ffd_pkg::*;

   logic               rsp_valid_ff;
   logic               ok_ff;
   logic               line_valid_ff;
   logic [7:0]         lost_ff;
   logic [9:0]         conf_ff;
   logic signed [15:0] lat_ff, hdg_ff, curv_ff;
   logic               marker_ff;
   logic [31:0]        time_ff;
   logic [31:0]        good_ff, bad_ff;

   // the record registers double as the response register, so a new frame
   // is only applied once the previous response has gone
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         ok_ff         <= 1'b0;
         line_valid_ff <= 1'b0;
         lost_ff       <= '0;
         conf_ff       <= '0;
         lat_ff        <= '0;
         hdg_ff        <= '0;
         curv_ff       <= '0;
         marker_ff     <= 1'b0;
         time_ff       <= '0;
         good_ff       <= '0;
         bad_ff        <= '0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            ok_ff        <= pop_data.ok;
            if (pop_data.ok) begin
               line_valid_ff <= pop_data.line_valid;
               lost_ff       <= pop_data.lines_lost;
               conf_ff       <= pop_data.confidence;
               lat_ff        <= pop_data.lateral;
               hdg_ff        <= pop_data.heading;
               curv_ff       <= pop_data.curvature;
               marker_ff     <= pop_data.marker;
               time_ff       <= pop_data.time_ms;
               good_ff       <= good_ff + 32'd1;
            end else begin
               bad_ff <= bad_ff + 32'd1;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.frame_ok       = ok_ff;
   assign rsp_ch.line_valid     = line_valid_ff;
   assign rsp_ch.lines_lost     = lost_ff;
   assign rsp_ch.confidence     = conf_ff;
   assign rsp_ch.lateral_offset = lat_ff;
   assign rsp_ch.heading_offset = hdg_ff;
   assign rsp_ch.curvature      = curv_ff;
   assign rsp_ch.marker_seen    = marker_ff;
   assign rsp_ch.received_ms    = time_ff;
   assign rsp_ch.good_frames    = good_ff;
   assign rsp_ch.bad_frames     = bad_ff;

endmodule
`default_nettype wire

// ===== sv/fixed_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// response: the last frame byte pushes the frame into the frame queue, and it is popped
//    into the response registers once the previous response has gone
// throughput: one request per cycle; ready falls only while the frame queue
//    (QUEUE_DEPTH entries) is full behind a stalled response
// at most one response per 19 bytes, set by the fixed frame length
// reset: hunting restarts, line record and both counters clear, registers
//    return to source 5, destination 4, message id 66, confidence limit 1000
// ----------------------------------------------------------------------------
// fixed_frame_deframer
// Serial frame parser for a fixed 19-byte line report frame.
// ----------------------------------------------------------------------------
module fixed_frame_deframer #(
   parameter int QUEUE_DEPTH = ffd_pkg::QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   ffd_req_if.sink   req_ch,
   ffd_rsp_if.source rsp_ch,
   ffd_csr_if.sink   csr_ch
);
   import ffd_pkg::*;

   logic         push;
   logic         pop;
   entry_type    push_data;
   entry_type    pop_data;
   q_status_type q_status;

   ffd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   ffd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   ffd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("frame pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("frame popped from empty queue");

   a_status_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_ch.valid)
      else $error("popped frame produced no response");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed frame deframer. Byte streams of good
// frames, damaged frames, noise, repeated headers and resyncs are fed in with
// random gaps. A local parser predicts each frame verdict and line record, and
// every response field is compared against it.
// ----------------------------------------------------------------------------
module tb;
   import ffd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_OCTETS  = 80;

   typedef struct {
      mode_type    mode;
      logic [7:0]  value;
      logic [31:0] stamp;
   } rx_octet_type;

   typedef struct {
      logic        ok;
      logic        line_valid;
      logic [7:0]  lines_lost;
      logic [9:0]  confidence;
      logic [15:0] lateral;
      logic [15:0] heading;
      logic [15:0] curvature;
      logic        marker;
      logic [31:0] stamp;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } line_report_type;

   typedef logic [7:0] frame_bytes_type [FRAME_LEN];

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffd_req_if req_bus();
   ffd_rsp_if rsp_bus();
   ffd_csr_if csr_bus();

   fixed_frame_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #5 clock = ~clock;

   // register copies
   logic [7:0]   cfg_source;
   logic [7:0]   cfg_destination;
   logic [7:0]   cfg_message_id;
   logic [15:0]  cfg_conf_limit;

   // parser copy
   int              frame_pos;
   logic [7:0]      frame_buf [FRAME_LEN];
   line_report_type latest_line;
   line_report_type expected_reports [$];

   rx_octet_type pending_octets [$];
   rx_octet_type octet_in_flight;
   logic [31:0]  stamp_ms;
   int           octets_queued;
   int           octets_accepted;
   int           error_count;
   int           gap_left;
   int           burst_left;
   int           hold_left;
   int           cycle_count;
   bit           sender_gaps;
   bit           long_holds;
   logic [15:0]  stall_pattern;

   task automatic report_error(input string what);
      error_count++;
      $display("%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   task automatic parse_octet(input rx_octet_type o);
      logic [15:0] conf;
      logic        good;
      if (o.mode == MODE_RESYNC) begin
         frame_pos = 0;
      end else if (frame_pos == 0) begin
         if (o.value == HEAD_A) begin
            frame_buf[0] = o.value;
            frame_pos = 1;
         end
      end else if (frame_pos == 1) begin
         if (o.value == HEAD_B) begin
            frame_buf[1] = o.value;
            frame_pos = 2;
         end else if (o.value != HEAD_A) begin
            // anything but a repeated header byte drops back to hunting
            frame_pos = 0;
         end
      end else begin
         frame_buf[frame_pos] = o.value;
         frame_pos++;
         if (frame_pos == FRAME_LEN) begin
            frame_pos = 0;
            conf = {frame_buf[OFS_CONF_H], frame_buf[OFS_CONF_L]};
            good = frame_buf[OFS_HEAD_A] == HEAD_A && frame_buf[OFS_HEAD_B] == HEAD_B &&
                   frame_buf[OFS_LEN] == LEN_BYTE && frame_buf[OFS_SRC] == cfg_source &&
                   frame_buf[OFS_DST] == cfg_destination &&
                   frame_buf[OFS_MSGID] == cfg_message_id &&
                   frame_buf[OFS_TAIL_A] == TAIL_A && frame_buf[OFS_TAIL_B] == TAIL_B &&
                   frame_buf[OFS_VALID] <= FLAG_MAX && frame_buf[OFS_MARKER] <= FLAG_MAX &&
                   conf <= cfg_conf_limit && conf <= CONF_MAX_STORABLE;
            if (good) begin
               latest_line.line_valid = frame_buf[OFS_VALID][0];
               latest_line.lines_lost = frame_buf[OFS_LOST];
               latest_line.confidence = conf[9:0];
               latest_line.lateral    = {frame_buf[OFS_LAT_H], frame_buf[OFS_LAT_L]};
               latest_line.heading    = {frame_buf[OFS_HDG_H], frame_buf[OFS_HDG_L]};
               latest_line.curvature  = {frame_buf[OFS_CURV_H], frame_buf[OFS_CURV_L]};
               latest_line.marker     = frame_buf[OFS_MARKER][0];
               latest_line.stamp      = o.stamp;
               latest_line.good_count++;
            end else begin
               latest_line.bad_count++;
            end
            latest_line.ok = good;
            expected_reports.push_back(latest_line);
         end
      end
   endtask

   function automatic frame_bytes_type build_frame(
      input logic [7:0]  valid_flag,
      input logic [7:0]  lost,
      input logic [15:0] conf,
      input logic [15:0] lateral,
      input logic [15:0] heading,
      input logic [15:0] curv,
      input logic [7:0]  marker_flag
   );
      frame_bytes_type f;
      f[OFS_HEAD_A] = HEAD_A;
      f[OFS_HEAD_B] = HEAD_B;
      f[OFS_LEN]    = LEN_BYTE;
      f[OFS_SRC]    = cfg_source;
      f[OFS_DST]    = cfg_destination;
      f[OFS_MSGID]  = cfg_message_id;
      f[OFS_VALID]  = valid_flag;
      f[OFS_LOST]   = lost;
      f[OFS_CONF_L] = conf[7:0];
      f[OFS_CONF_H] = conf[15:8];
      f[OFS_LAT_L]  = lateral[7:0];
      f[OFS_LAT_H]  = lateral[15:8];
      f[OFS_HDG_L]  = heading[7:0];
      f[OFS_HDG_H]  = heading[15:8];
      f[OFS_CURV_L] = curv[7:0];
      f[OFS_CURV_H] = curv[15:8];
      f[OFS_MARKER] = marker_flag;
      f[OFS_TAIL_A] = TAIL_A;
      f[OFS_TAIL_B] = TAIL_B;
      return f;
   endfunction

   task automatic push_octet(input mode_type m, input logic [7:0] v);
      rx_octet_type o;
      // mostly a slowly rising clock, now and then a jump anywhere
      if ($urandom_range(0, 15) == 0) stamp_ms = $urandom;
      else stamp_ms = stamp_ms + $urandom_range(0, 40);
      o.mode  = m;
      o.value = v;
      o.stamp = stamp_ms;
      pending_octets.push_back(o);
      octets_queued++;
   endtask

   task automatic push_frame(input frame_bytes_type f, input int upto);
      for (int i = 0; i < upto; i++) push_octet(MODE_DATA, f[i]);
   endtask

   task automatic queue_random_frame();
      frame_bytes_type f;
      logic [15:0]     lim;
      logic [15:0]     conf;
      logic [7:0]      valid_flag;
      logic [7:0]      marker_flag;
      int              hit;
      lim = (cfg_conf_limit > CONF_MAX_STORABLE) ? CONF_MAX_STORABLE : cfg_conf_limit;
      case ($urandom_range(0, 7))
         0: conf = lim;
         1: conf = lim + 16'd1;
         2: conf = 16'($urandom);
         default: conf = 16'($urandom_range(0, lim));
      endcase
      valid_flag  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      marker_flag = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      f = build_frame(valid_flag, 8'($urandom), conf, 16'($urandom), 16'($urandom),
                      16'($urandom), marker_flag);
      if ($urandom_range(0, 5) == 0) begin
         hit = $urandom_range(0, FRAME_LEN - 1);
         f[hit] = f[hit] ^ 8'($urandom_range(1, 255));
      end
      case ($urandom_range(0, 11))
         0, 1: repeat ($urandom_range(1, 3)) push_octet(MODE_DATA, HEAD_A);
         2: repeat ($urandom_range(1, 6)) push_octet(MODE_DATA, 8'($urandom));
         3: begin
            push_octet(MODE_DATA, HEAD_A);
            push_octet(MODE_DATA, 8'($urandom));
         end
         4: begin
            push_frame(f, $urandom_range(1, FRAME_LEN - 1));
            push_octet(MODE_RESYNC, 8'($urandom));
         end
         5: push_octet(MODE_RESYNC, 8'($urandom));
         // cut short with no resync, so the next frame lands mid-body
         6: push_frame(f, $urandom_range(3, FRAME_LEN - 1));
         default: ;
      endcase
      push_frame(f, FRAME_LEN);
   endtask

   task automatic wait_idle();
      while (octets_accepted != octets_queued || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_phase();
      int start;
      start = octets_queued;
      sender_gaps   = $urandom_range(0, 2) != 0;
      long_holds    = 1'($urandom_range(0, 1));
      // bit 0 kept clear so the receiver is ready at least once per rotation
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
      while (octets_queued - start < PHASE_OCTETS) queue_random_frame();
      wait_idle();
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_SRC_ADDR:   cfg_source      = value[7:0];
         CSR_DST_ADDR:   cfg_destination = value[7:0];
         CSR_MSG_ID:     cfg_message_id  = value[7:0];
         CSR_CONF_LIMIT: cfg_conf_limit  = value;
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [7:0] src, input logic [7:0] dst,
                                input logic [7:0] msg, input logic [15:0] limit);
      // upper bits of the byte-wide registers carry junk
      write_register(CSR_SRC_ADDR, {8'($urandom), src});
      write_register(CSR_DST_ADDR, {8'($urandom), dst});
      write_register(CSR_MSG_ID, {8'($urandom), msg});
      write_register(CSR_CONF_LIMIT, limit);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_octet(octet_in_flight);
            octets_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_octets.size() != 0) begin
               octet_in_flight = pending_octets.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.mode       <= octet_in_flight.mode;
               req_bus.byte_value <= octet_in_flight.value;
               req_bus.now_ms     <= octet_in_flight.stamp;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = sender_gaps ? $urandom_range(1, 6) : 0;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      line_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               report_error("response with no frame pending");
            end else begin
               want = expected_reports.pop_front();
               check_field("frame_ok", 32'(rsp_bus.frame_ok), 32'(want.ok));
               check_field("line_valid", 32'(rsp_bus.line_valid), 32'(want.line_valid));
               check_field("lines_lost", 32'(rsp_bus.lines_lost), 32'(want.lines_lost));
               check_field("confidence", 32'(rsp_bus.confidence), 32'(want.confidence));
               check_field("lateral_offset", 32'($unsigned(rsp_bus.lateral_offset)),
                           32'(want.lateral));
               check_field("heading_offset", 32'($unsigned(rsp_bus.heading_offset)),
                           32'(want.heading));
               check_field("curvature", 32'($unsigned(rsp_bus.curvature)),
                           32'(want.curvature));
               check_field("marker_seen", 32'(rsp_bus.marker_seen), 32'(want.marker));
               check_field("received_ms", rsp_bus.received_ms, want.stamp);
               check_field("good_frames", rsp_bus.good_frames, want.good_count);
               check_field("bad_frames", rsp_bus.bad_frames, want.bad_count);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            rsp_bus.ready <= !stall_pattern[0];
            // long holds fill the frame queue and push back on requests
            if (long_holds && $urandom_range(0, 149) == 0) hold_left = $urandom_range(20, 120);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      frame_bytes_type f;
      frame_bytes_type good_frame;
      pos_type         fixed_ofs [6];
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_DATA;
      req_bus.byte_value = 8'h00;
      req_bus.now_ms     = 32'h0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_SRC_ADDR;
      csr_bus.data       = 16'h0;
      rsp_bus.ready      = 1'b1;
      cfg_source         = SRC_RESET;
      cfg_destination    = DST_RESET;
      cfg_message_id     = MSGID_RESET;
      cfg_conf_limit     = CONF_LIMIT_RESET;
      frame_pos          = 0;
      latest_line        = '{default: '0};
      stamp_ms           = 32'hFFFF_FF00;
      stall_pattern      = 16'h0000;
      sender_gaps        = 1'b0;
      long_holds         = 1'b0;
      fixed_ofs = '{OFS_LEN, OFS_SRC, OFS_DST, OFS_MSGID, OFS_TAIL_A, OFS_TAIL_B};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset register values, field extremes
      f = build_frame(8'd1, 8'hFF, 16'd1000, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd1);
      push_frame(f, FRAME_LEN);
      good_frame = build_frame(8'd0, 8'h00, 16'd0, 16'h7FFF, 16'h8000, 16'h0000, 8'd0);
      push_frame(good_frame, FRAME_LEN);
      // repeated header byte keeps the frame start
      push_octet(MODE_DATA, HEAD_A);
      push_frame(good_frame, FRAME_LEN);
      // stray byte after the first header byte restarts the hunt
      push_octet(MODE_DATA, HEAD_A);
      push_octet(MODE_DATA, 8'h12);
      push_frame(good_frame, FRAME_LEN);
      // resync drops a half-built frame
      push_frame(good_frame, 10);
      push_octet(MODE_RESYNC, 8'hFF);
      push_frame(good_frame, FRAME_LEN);
      // confidence just over the limit, flag bytes out of range
      f = build_frame(8'd1, 8'd3, 16'd1001, 16'h0001, 16'hFFFE, 16'h1234, 8'd0);
      push_frame(f, FRAME_LEN);
      f = build_frame(8'd2, 8'd3, 16'd10, 16'h0001, 16'hFFFE, 16'h1234, 8'd0);
      push_frame(f, FRAME_LEN);
      f = build_frame(8'd1, 8'd3, 16'd10, 16'h0001, 16'hFFFE, 16'h1234, 8'hFF);
      push_frame(f, FRAME_LEN);
      // length, address, message id and tail bytes each wrong in turn
      for (int k = 0; k < 6; k++) begin
         f = good_frame;
         f[fixed_ofs[k]] = f[fixed_ofs[k]] ^ 8'h01;
         push_frame(f, FRAME_LEN);
      end
      push_frame(good_frame, FRAME_LEN);
      queue_random_phase();

      // low extremes: zero limit passes only zero confidence
      set_registers(8'h00, 8'hFF, 8'h00, 16'h0000);
      f = build_frame(8'd1, 8'd7, 16'd0, 16'h00FF, 16'hFF00, 16'h8001, 8'd1);
      push_frame(f, FRAME_LEN);
      f = build_frame(8'd1, 8'd7, 16'd1, 16'h00FF, 16'hFF00, 16'h8001, 8'd1);
      push_frame(f, FRAME_LEN);
      queue_random_phase();

      // high extremes: limit above what ten bits can hold
      set_registers(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
      f = build_frame(8'd0, 8'd1, 16'd1023, 16'h5555, 16'hAAAA, 16'h7FFF, 8'd1);
      push_frame(f, FRAME_LEN);
      f = build_frame(8'd0, 8'd1, 16'd1024, 16'h5555, 16'hAAAA, 16'h7FFF, 8'd1);
      push_frame(f, FRAME_LEN);
      f = build_frame(8'd0, 8'd1, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF, 8'd1);
      push_frame(f, FRAME_LEN);
      queue_random_phase();

      repeat (2) begin
         case ($urandom_range(0, 2))
            0: set_registers(8'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom_range(0, 1023)));
            1: set_registers(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
            default: set_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                   CONF_LIMIT_RESET);
         endcase
         queue_random_phase();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== fixed_frame_deframer.f =====
sv/ffd_pkg.sv
sv/ffd_req_if.sv
sv/ffd_rsp_if.sv
sv/ffd_csr_if.sv
sv/ffd_queue.sv
sv/ffd_front.sv
sv/ffd_back.sv
sv/fixed_frame_deframer.sv
test/tb.sv
